FILE: hdl/variable_delay_cubic_feedback_top_assert.svh
// Assertion macros for the variable delay block.
`ifndef VARIABLE_DELAY_CUBIC_FEEDBACK_TOP_ASSERT_SVH
`define VARIABLE_DELAY_CUBIC_FEEDBACK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VDCF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define VDCF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define VDCF_ASSERT_IMP(name, clk, rst, ante, cons)
`define VDCF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/vdcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vdcf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MUL_W = 21;
  localparam int PROD_W = 2 * MUL_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MUL_W-1:0] mul_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Feedback weights 0.6 and 0.4 in Q1.15.
  localparam mul_t FB_DRY = 21'sd19661;
  localparam mul_t FB_WET = 21'sd13107;

  // Reciprocal of six, scaled by 2^DIV6_SHIFT and truncated.
  localparam mul_t DIV6_K = 21'sd174762;
  localparam int DIV6_SHIFT = 20;

  localparam logic REG_SPM = 1'b0;
  localparam logic REG_MAXD = 1'b1;

endpackage
`default_nettype wire

FILE: hdl/vdcf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module vdcf_mul (
  input  wire logic             clk,
  input  wire vdcf_pkg::mul_t   op_a,
  input  wire vdcf_pkg::mul_t   op_b,
  output vdcf_pkg::prod_t       prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

FILE: hdl/vdcf_ring.sv
`timescale 1ns / 1ps
`default_nettype none
module vdcf_ring #(
  parameter int LINE_DEPTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [$clog2(LINE_DEPTH)-1:0] raddr,
  output vdcf_pkg::sample_t                  rdata,
  input  wire logic                          wen,
  input  wire logic [$clog2(LINE_DEPTH)-1:0] waddr,
  input  wire vdcf_pkg::sample_t             wdata,
  output logic                               busy
);

  localparam int AW = $clog2(LINE_DEPTH);

  vdcf_pkg::sample_t mem [LINE_DEPTH];
  logic [AW-1:0] clr_addr;

  // After reset every entry is written with zero, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(LINE_DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/vdcf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module vdcf_ctrl #(
  parameter int LINE_DEPTH = 4096,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [15:0]                   spm,
  input  wire logic [11:0]                   maxd,
  input  wire logic                          ring_busy,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire vdcf_pkg::sample_t             sample_in,
  input  wire logic [15:0]                   delay_msec,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output vdcf_pkg::sample_t                  sample_out,
  output logic [$clog2(LINE_DEPTH)-1:0]      raddr,
  input  wire vdcf_pkg::sample_t             rdata,
  output logic                               wen,
  output logic [$clog2(LINE_DEPTH)-1:0]      waddr,
  output vdcf_pkg::sample_t                  wdata,
  output vdcf_pkg::mul_t                     op_a,
  output vdcf_pkg::mul_t                     op_b,
  input  wire vdcf_pkg::prod_t               prod
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = (AW > 12) ? AW : 12;
  localparam int DQW = 16 + FRAC_BITS;
  localparam int HW = CW + FRAC_BITS;
  localparam int XW = (DQW > HW) ? DQW : HW;
  localparam int ONE = 1 << FRAC_BITS;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DLY   = 5'd1;
  localparam logic [4:0] ST_CLAMP = 5'd2;
  localparam logic [4:0] ST_BASE  = 5'd3;
  localparam logic [4:0] ST_RA    = 5'd4;
  localparam logic [4:0] ST_RB    = 5'd5;
  localparam logic [4:0] ST_RC    = 5'd6;
  localparam logic [4:0] ST_RD    = 5'd7;
  localparam logic [4:0] ST_T1    = 5'd8;
  localparam logic [4:0] ST_M1    = 5'd9;
  localparam logic [4:0] ST_T2    = 5'd10;
  localparam logic [4:0] ST_M2    = 5'd11;
  localparam logic [4:0] ST_R2    = 5'd12;
  localparam logic [4:0] ST_M3    = 5'd13;
  localparam logic [4:0] ST_Q     = 5'd14;
  localparam logic [4:0] ST_V3    = 5'd15;
  localparam logic [4:0] ST_M4    = 5'd16;
  localparam logic [4:0] ST_Y     = 5'd17;
  localparam logic [4:0] ST_F1    = 5'd18;
  localparam logic [4:0] ST_F2    = 5'd19;
  localparam logic [4:0] ST_F3    = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;

  // Round to nearest with ties away from zero, then shift right.
  function automatic vdcf_pkg::prod_t rnd_shift(input vdcf_pkg::prod_t v, input int s);
    vdcf_pkg::prod_t half;
    half = vdcf_pkg::prod_t'(1) <<< (s - 1);
    if (v < 0) begin
      rnd_shift = (v + half - vdcf_pkg::prod_t'(1)) >>> s;
    end else begin
      rnd_shift = (v + half) >>> s;
    end
  endfunction

  function automatic vdcf_pkg::sample_t sat16(input vdcf_pkg::mul_t v);
    if (v > vdcf_pkg::mul_t'(32767)) begin
      sat16 = 16'sh7fff;
    end else if (v < vdcf_pkg::mul_t'(-32768)) begin
      sat16 = -16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  logic [4:0] state;
  logic [AW-1:0] wr_idx;

  vdcf_pkg::sample_t dry;
  logic [15:0] dms;
  logic [AW-1:0] n;
  logic [FRAC_BITS-1:0] f;
  logic [AW-1:0] base;
  vdcf_pkg::sample_t ta;
  vdcf_pkg::sample_t tb;
  vdcf_pkg::mul_t cmb;
  vdcf_pkg::mul_t v1;
  vdcf_pkg::mul_t e;
  vdcf_pkg::mul_t t;
  vdcf_pkg::mul_t m;
  logic neg;
  vdcf_pkg::mul_t q;
  vdcf_pkg::mul_t v3;
  vdcf_pkg::sample_t dly;
  vdcf_pkg::prod_t acc;
  vdcf_pkg::sample_t fb;

  logic [DQW-1:0] dq_raw;
  logic [CW-1:0] mx_ext;
  logic [CW-1:0] mx_c;
  logic [XW-1:0] dq_lo;
  logic [XW-1:0] dq_hi;
  logic [XW-1:0] dq_a;
  logic [XW-1:0] dq;
  logic [AW:0] bdiff;
  logic [AW-1:0] base_next;
  vdcf_pkg::mul_t f_ext;
  vdcf_pkg::prod_t rf;
  vdcf_pkg::mul_t rf_w;
  vdcf_pkg::mul_t q0;
  vdcf_pkg::mul_t rem;
  logic signed [16:0] ysum;
  logic out_load;

  assign dq_raw = prod[31 -: DQW];
  assign mx_ext = CW'(maxd);
  assign mx_c = (mx_ext < CW'(2)) ? CW'(2) :
                (mx_ext > CW'(LINE_DEPTH - 4)) ? CW'(LINE_DEPTH - 4) : mx_ext;
  assign dq_lo = XW'(ONE + 1);
  assign dq_hi = XW'({mx_c, {FRAC_BITS{1'b0}}});
  assign dq_a = (XW'(dq_raw) < dq_lo) ? dq_lo : XW'(dq_raw);
  assign dq = (dq_a > dq_hi) ? dq_hi : dq_a;

  assign bdiff = {1'b0, wr_idx} - {1'b0, n};
  assign base_next = bdiff[AW] ? AW'(bdiff + (AW + 1)'(LINE_DEPTH)) : bdiff[AW-1:0];

  assign f_ext = {{(vdcf_pkg::MUL_W - FRAC_BITS){1'b0}}, f};
  assign rf = rnd_shift(prod, FRAC_BITS);
  assign rf_w = vdcf_pkg::mul_t'(rf);
  assign q0 = vdcf_pkg::mul_t'(prod >>> vdcf_pkg::DIV6_SHIFT);
  assign rem = m - (q0 <<< 2) - (q0 <<< 1);
  assign ysum = {dry[15], dry} + {dly[15], dly};

  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);
  assign in_stall = (state != ST_IDLE) || ring_busy;

  assign wen = out_load;
  assign waddr = wr_idx;
  assign wdata = fb;

  always_comb begin
    unique case (state)
      ST_RA: raddr = (base == AW'(LINE_DEPTH - 1)) ? '0 : base + AW'(1);
      ST_RC: raddr = (base == '0) ? AW'(LINE_DEPTH - 1) : base - AW'(1);
      ST_RD: raddr = (base < AW'(2)) ? base + AW'(LINE_DEPTH - 2) : base - AW'(2);
      default: raddr = base;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_DLY: begin
        op_a = {{(vdcf_pkg::MUL_W - 16){1'b0}}, dms};
        op_b = {{(vdcf_pkg::MUL_W - 16){1'b0}}, spm};
      end
      ST_M1: begin
        op_a = v1;
        op_b = f_ext;
      end
      ST_M2: begin
        op_a = t;
        op_b = vdcf_pkg::mul_t'(ONE) - f_ext;
      end
      ST_M3: begin
        op_a = m;
        op_b = vdcf_pkg::DIV6_K;
      end
      ST_M4: begin
        op_a = v3;
        op_b = f_ext;
      end
      ST_F1: begin
        op_a = vdcf_pkg::mul_t'(dry);
        op_b = vdcf_pkg::FB_DRY;
      end
      ST_F2: begin
        op_a = vdcf_pkg::mul_t'(dly);
        op_b = vdcf_pkg::FB_WET;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            state <= ST_DLY;
          end
        end
        ST_DLY:   state <= ST_CLAMP;
        ST_CLAMP: state <= ST_BASE;
        ST_BASE:  state <= ST_RA;
        ST_RA:    state <= ST_RB;
        ST_RB:    state <= ST_RC;
        ST_RC:    state <= ST_RD;
        ST_RD:    state <= ST_T1;
        ST_T1:    state <= ST_M1;
        ST_M1:    state <= ST_T2;
        ST_T2:    state <= ST_M2;
        ST_M2:    state <= ST_R2;
        ST_R2:    state <= ST_M3;
        ST_M3:    state <= ST_Q;
        ST_Q:     state <= ST_V3;
        ST_V3:    state <= ST_M4;
        ST_M4:    state <= ST_Y;
        ST_Y:     state <= ST_F1;
        ST_F1:    state <= ST_F2;
        ST_F2:    state <= ST_F3;
        ST_F3:    state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            wr_idx <= (wr_idx == AW'(LINE_DEPTH - 1)) ? '0 : wr_idx + AW'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dry <= sample_in;
        dms <= delay_msec;
      end
      ST_CLAMP: begin
        n <= dq[FRAC_BITS +: AW];
        f <= dq[FRAC_BITS-1:0];
      end
      ST_BASE: base <= base_next;
      ST_RB: ta <= rdata;
      ST_RC: tb <= rdata;
      ST_RD: cmb <= vdcf_pkg::mul_t'(rdata) - vdcf_pkg::mul_t'(tb);
      ST_T1: begin
        v1 <= vdcf_pkg::mul_t'(rdata) - vdcf_pkg::mul_t'(ta) - (cmb + (cmb <<< 1));
        e <= vdcf_pkg::mul_t'(rdata) + (vdcf_pkg::mul_t'(ta) <<< 1)
             - (vdcf_pkg::mul_t'(tb) + (vdcf_pkg::mul_t'(tb) <<< 1));
      end
      ST_T2: t <= rf_w + e;
      ST_R2: begin
        neg <= rf_w[vdcf_pkg::MUL_W-1];
        m <= (rf_w[vdcf_pkg::MUL_W-1] ? -rf_w : rf_w) + vdcf_pkg::mul_t'(3);
      end
      ST_Q: q <= (rem >= vdcf_pkg::mul_t'(6)) ? q0 + vdcf_pkg::mul_t'(1) : q0;
      ST_V3: v3 <= cmb - (neg ? -q : q);
      ST_Y: dly <= sat16(vdcf_pkg::mul_t'(tb) + rf_w);
      ST_F2: acc <= prod;
      ST_F3: fb <= sat16(vdcf_pkg::mul_t'(rnd_shift(acc + prod, 15)));
      ST_OUT: begin
        if (out_load) begin
          sample_out <= ysum[16:1];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/variable_delay_cubic_feedback_top.sv
// Variable fractional delay with four-point cubic interpolation and feedback.
// The input channel (in_valid, in_stall) carries one Q1.15 sample and a delay in
// milliseconds per item; the output channel (out_valid, out_stall) returns one
// sample per item, half dry plus half delayed. Registers are written through
// cfg_wr_en, cfg_index and cfg_data; the user must write them only while the
// block is idle, as the block does not enforce it. An item is processed by a
// sequencer around one shared multiplier and a single-read-port ring memory:
// seven multiplications and four ring reads in sequence. A new item is
// accepted only once the previous result has gone into the output register.
// After reset all LINE_DEPTH ring entries (4096 by default) are cleared one
// per cycle; in_stall stays high during that pass.
// A finished result sits in an output register. While the receiver stalls it,
// the next item may still be accepted and computed, but its result waits in
// the last step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "variable_delay_cubic_feedback_top_assert.svh"
module variable_delay_cubic_feedback_top #(
  parameter int LINE_DEPTH = 4096,
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire vdcf_pkg::sample_t sample_in,
  input  wire logic [15:0] delay_msec,
  output logic             out_valid,
  input  wire logic        out_stall,
  output vdcf_pkg::sample_t sample_out,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [15:0] samples_per_msec;
  logic [11:0] max_delay_samples;

  logic ring_busy;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic wen;
  vdcf_pkg::sample_t rdata;
  vdcf_pkg::sample_t wdata;
  vdcf_pkg::mul_t op_a;
  vdcf_pkg::mul_t op_b;
  vdcf_pkg::prod_t prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_msec <= 16'd12288;
      max_delay_samples <= 12'd4092;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vdcf_pkg::REG_SPM:  samples_per_msec <= cfg_data;
        vdcf_pkg::REG_MAXD: max_delay_samples <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  vdcf_ring #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ring (
    .clk(clk),
    .rst(rst),
    .raddr(raddr),
    .rdata(rdata),
    .wen(wen),
    .waddr(waddr),
    .wdata(wdata),
    .busy(ring_busy)
  );

  vdcf_mul u_mul (
    .clk(clk),
    .op_a(op_a),
    .op_b(op_b),
    .prod(prod)
  );

  vdcf_ctrl #(
    .LINE_DEPTH(LINE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .spm(samples_per_msec),
    .maxd(max_delay_samples),
    .ring_busy(ring_busy),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .delay_msec(delay_msec),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .raddr(raddr),
    .rdata(rdata),
    .wen(wen),
    .waddr(waddr),
    .wdata(wdata),
    .op_a(op_a),
    .op_b(op_b),
    .prod(prod)
  );

  `VDCF_ASSERT_IMP(a_clear_blocks_input, clk, rst, ring_busy, in_stall)
  `VDCF_ASSERT_IMP(a_clear_no_result, clk, rst, ring_busy, !out_valid)
  `VDCF_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int RING_DEPTH = 4096;
  localparam int FRAC_W = 8;
  localparam longint WEIGHT_DRY = 19661;
  localparam longint WEIGHT_WET = 13107;
  localparam int NUM_SETTINGS = 10;
  localparam int ITEMS_PER_SETTING = 170;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int unsigned SPM_SET [NUM_SETTINGS] =
    '{12288, 256, 0, 65535, 3000, 12288, 777, 65535, 40, 12288};
  localparam int unsigned MAXD_SET [NUM_SETTINGS] =
    '{4092, 4092, 100, 4095, 1, 0, 2, 4092, 4092, 600};

  typedef struct {
    vdcf_pkg::sample_t smp;
    logic [15:0]       dms;
    bit                drain;
  } pending_item_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  vdcf_pkg::sample_t sample_in = '0;
  logic [15:0]       delay_msec = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  vdcf_pkg::sample_t sample_out;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = vdcf_pkg::REG_SPM;
  logic [15:0]       cfg_data = '0;

  pending_item_t     pending_q [$];
  vdcf_pkg::sample_t expected_mix_q [$];

  vdcf_pkg::sample_t ring_copy [0:RING_DEPTH-1];
  logic [11:0] write_ptr = '0;
  logic [15:0] spm_q = 16'd12288;
  logic [11:0] maxd_q = 12'd4092;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int short_clamps = 0;
  int long_clamps = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int recv_calm = 0;

  variable_delay_cubic_feedback_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .delay_msec (delay_msec),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint frac_scale(longint v, longint f);
    return round_shift(v * f, FRAC_W);
  endfunction

  function automatic longint sixth(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 3) / 6;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint ring_tap(int back);
    logic [11:0] idx;
    idx = write_ptr - 12'(back);
    return longint'(ring_copy[idx]);
  endfunction

  // Computes the mixed output for one item and updates the ring copy.
  function automatic vdcf_pkg::sample_t delay_mix_predict(vdcf_pkg::sample_t dry,
                                                          logic [15:0] dms);
    longint lim, dq, f, a, b, c, d, cmb, t, s, wet, fb;
    int n, sum;
    lim = longint'(maxd_q);
    if (lim < 2) lim = 2;
    if (lim > RING_DEPTH - 4) lim = RING_DEPTH - 4;
    dq = (longint'(dms) * longint'(spm_q)) >>> (16 - FRAC_W);
    if (dq < (64'sd1 <<< FRAC_W) + 1) begin
      dq = (64'sd1 <<< FRAC_W) + 1;
      short_clamps++;
    end
    if (dq > (lim <<< FRAC_W)) begin
      dq = lim <<< FRAC_W;
      long_clamps++;
    end
    n = int'(dq >>> FRAC_W);
    f = dq & ((64'sd1 <<< FRAC_W) - 1);
    a = ring_tap(n - 1);
    b = ring_tap(n);
    c = ring_tap(n + 1);
    d = ring_tap(n + 2);
    cmb = c - b;
    t = frac_scale(d - a - 3 * cmb, f) + (d + 2 * a - 3 * b);
    s = sixth(frac_scale(t, (64'sd1 <<< FRAC_W) - f));
    wet = clip16(b + frac_scale(cmb - s, f));
    sum = int'(dry) + int'(wet);
    fb = clip16(round_shift(WEIGHT_DRY * longint'(dry) + WEIGHT_WET * wet, 15));
    ring_copy[write_ptr] = vdcf_pkg::sample_t'(fb);
    write_ptr = write_ptr + 12'd1;
    return vdcf_pkg::sample_t'(sum >>> 1);
  endfunction

  function automatic int next_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task automatic queue_item(vdcf_pkg::sample_t smp, logic [15:0] dms, bit drain);
    pending_item_t it;
    it.smp = smp;
    it.dms = dms;
    it.drain = drain;
    pending_q.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == vdcf_pkg::REG_SPM) spm_q = val;
    else maxd_q = val[11:0];
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_mix_q.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    pending_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_mix_q.push_back(delay_mix_predict(sample_in, delay_msec));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && expected_mix_q.size() > 0)) begin
          next_item = pending_q.pop_front();
          in_valid <= 1'b1;
          sample_in <= next_item.smp;
          delay_msec <= next_item.dms;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            if ($urandom_range(0, 63) == 0) send_calm = $urandom_range(20, 80);
            send_gap = next_idle();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    vdcf_pkg::sample_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_mix_q.size() == 0) begin
          report_mismatch($sformatf("sample_out %0d arrived with no item pending",
                                    sample_out));
        end else begin
          want = expected_mix_q.pop_front();
          if (sample_out !== want)
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      results_checked, sample_out, want));
          results_checked++;
        end
      end
      if (stall_left == 0) begin
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          if ($urandom_range(0, 63) == 0) recv_calm = $urandom_range(20, 80);
          stall_left = next_idle();
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    vdcf_pkg::sample_t smp;
    logic [15:0]       dms;
    logic [3:0]        pad;
    int                r;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings: shortest delay with the oldest
    // slot as a tap, the long clamp, fractional delays and extreme samples.
    queue_item(16'sh7FFF, 16'h0000, 1'b0);
    queue_item(16'sh8000, 16'h0000, 1'b0);
    queue_item(16'sh7FFF, 16'h0010, 1'b0);
    queue_item(16'sh8000, 16'h0011, 1'b0);
    queue_item(16'sh7FFF, 16'h0005, 1'b0);
    queue_item(16'sh0000, 16'h0006, 1'b0);
    queue_item(-16'sd1, 16'hFFFF, 1'b0);
    queue_item(16'sh0001, 16'h0155, 1'b0);
    queue_item(16'sh5555, 16'h2AAA, 1'b0);
    queue_item(16'shAAAA, 16'h5555, 1'b0);
    for (int i = 0; i < 12; i++)
      queue_item((i % 2) ? 16'sh7FFF : 16'sh8000, 16'(i + 6), 1'b0);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        wait_idle();
        write_reg(vdcf_pkg::REG_SPM, 16'(SPM_SET[p]));
        pad = 4'($urandom);
        write_reg(vdcf_pkg::REG_MAXD, {pad, 12'(MAXD_SET[p])});
      end
      for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          case ($urandom_range(0, 3))
            0: smp = 16'sh7FFF;
            1: smp = 16'sh8000;
            2: smp = 16'sh0000;
            default: smp = -16'sd1;
          endcase
        end else begin
          smp = vdcf_pkg::sample_t'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r == 0) dms = 16'($urandom_range(0, 7));
        else if (r == 1) dms = 16'(32'hFFFF - $urandom_range(0, 255));
        else dms = 16'($urandom & ((32'd1 << $urandom_range(1, 16)) - 1));
        queue_item(smp, dms, k == 60);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Run covered %0d items over %0d register settings, %0d results compared.",
             items_sent, NUM_SETTINGS, results_checked);
    $display("Delays raised to the minimum: %0d, lowered to the maximum: %0d.",
             short_clamps, long_clamps);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
